// ----- sv/dkt_pkg.sv -----
// ----------------------------------------------------------------------------
// dkt_pkg: shared types, constants and helpers of the dual key task table
// widths, operation and status codes, beat structs, sequencer states
// ----------------------------------------------------------------------------
package dkt_pkg;

  // table geometry
  localparam int SLOTS    = 100;
  localparam int IDX_W    = $clog2(SLOTS);
  localparam int MAX_PRIO = 99;
  localparam int LAST_P   = (SLOTS - 1 < MAX_PRIO) ? SLOTS - 1 : MAX_PRIO;

  // field widths
  localparam int MODE_W = 3;
  localparam int PRIO_W = 7;
  localparam int HOUR_W = 5;
  localparam int MIN_W  = 6;
  localparam int SEC_W  = 6;
  localparam int ARR_W  = 17;
  localparam int CNT_W  = 7;
  localparam int STAT_W = 3;

  localparam logic [PRIO_W-1:0] LAST_PRIO = PRIO_W'(LAST_P);
  localparam logic [IDX_W-1:0]  FIRST_IDX = IDX_W'(1);
  localparam logic [IDX_W-1:0]  LAST_IDX  = IDX_W'(LAST_P);
  localparam logic [CNT_W-1:0]  MAX_TASKS = CNT_W'(99);
  localparam logic [ARR_W-1:0]  DAY_LAST  = ARR_W'(86399);
  localparam logic [ARR_W-1:0]  SEC_HOUR  = ARR_W'(3600);
  localparam logic [ARR_W-1:0]  SEC_MIN   = ARR_W'(60);

  // operation codes
  localparam logic [MODE_W-1:0] MODE_ADD        = MODE_W'(0);
  localparam logic [MODE_W-1:0] MODE_POP_MAX    = MODE_W'(1);
  localparam logic [MODE_W-1:0] MODE_POP_EARLY  = MODE_W'(2);
  localparam logic [MODE_W-1:0] MODE_PEEK_MAX   = MODE_W'(3);
  localparam logic [MODE_W-1:0] MODE_PEEK_EARLY = MODE_W'(4);
  localparam logic [MODE_W-1:0] MODE_CHG_PRIO   = MODE_W'(5);
  localparam logic [MODE_W-1:0] MODE_CHG_TIME   = MODE_W'(6);

  // status codes
  localparam logic [STAT_W-1:0] STAT_OK       = STAT_W'(0);
  localparam logic [STAT_W-1:0] STAT_EMPTY    = STAT_W'(1);
  localparam logic [STAT_W-1:0] STAT_FULL     = STAT_W'(2);
  localparam logic [STAT_W-1:0] STAT_INUSE    = STAT_W'(3);
  localparam logic [STAT_W-1:0] STAT_NOTFOUND = STAT_W'(4);
  localparam logic [STAT_W-1:0] STAT_BADPRIO  = STAT_W'(5);

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [PRIO_W-1:0] priority_req;
    logic [PRIO_W-1:0] new_priority;
    logic [HOUR_W-1:0] hours;
    logic [MIN_W-1:0]  minutes;
    logic [SEC_W-1:0]  seconds;
    logic [HOUR_W-1:0] new_hours;
    logic [MIN_W-1:0]  new_minutes;
    logic [SEC_W-1:0]  new_seconds;
  } dkt_in_t;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [PRIO_W-1:0] task_priority;
    logic [ARR_W-1:0]  arrival_seconds;
    logic [CNT_W-1:0]  task_count;
  } dkt_out_t;

  // arrival ram access request
  typedef struct packed {
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    logic [ARR_W-1:0] wr_data;
    logic [IDX_W-1:0] rd_addr;
  } dkt_ram_req_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_MOVE,
    S_SCAN,
    S_WAIT,
    S_FINISH,
    S_RESP
  } dkt_state_e;

  // hh*3600 + mm*60 + ss, clipped to the last second of the day
  function automatic logic [ARR_W-1:0] to_seconds(input logic [HOUR_W-1:0] h,
                                                  input logic [MIN_W-1:0]  m,
                                                  input logic [SEC_W-1:0]  s);
    logic [ARR_W-1:0] t;
    t = ARR_W'(h) * SEC_HOUR + ARR_W'(m) * SEC_MIN + ARR_W'(s);
    return (t > DAY_LAST) ? DAY_LAST : t;
  endfunction

  function automatic logic prio_valid(input logic [PRIO_W-1:0] p);
    return (p != '0) && (p <= LAST_PRIO);
  endfunction

  function automatic logic [IDX_W-1:0] to_idx(input logic [PRIO_W-1:0] p);
    logic [PRIO_W+IDX_W-1:0] w;
    w = {{IDX_W{1'b0}}, p};
    return w[IDX_W-1:0];
  endfunction

  function automatic logic [PRIO_W-1:0] to_prio(input logic [IDX_W-1:0] i);
    logic [PRIO_W+IDX_W-1:0] w;
    w = {{PRIO_W{1'b0}}, i};
    return w[PRIO_W-1:0];
  endfunction

endpackage

// ----- sv/dkt_arrival_ram.sv -----
// ----------------------------------------------------------------------------
// dkt_arrival_ram: arrival time store
// one write port, one read port, read data registered
// ----------------------------------------------------------------------------
module dkt_arrival_ram (
  input  logic                           clk_i,
  input  dkt_pkg::dkt_ram_req_t          req_i,
  output logic [dkt_pkg::ARR_W-1:0]      rd_data_o
);

  logic [dkt_pkg::ARR_W-1:0] mem_q [dkt_pkg::SLOTS];
  logic [dkt_pkg::ARR_W-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (req_i.wr_en) begin
      mem_q[req_i.wr_addr] <= req_i.wr_data;
    end
    rd_data_q <= mem_q[req_i.rd_addr];
  end

  assign rd_data_o = rd_data_q;

endmodule

// ----- sv/dkt_seq.sv -----
// ----------------------------------------------------------------------------
// dkt_seq: operation sequencer of the task table
// occupancy flags, task count, slot scan and read-modify-write of the ram
// ----------------------------------------------------------------------------
module dkt_seq (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  dkt_pkg::dkt_in_t              req_i,
  output logic                          busy_o,
  output logic                          res_valid_o,
  output dkt_pkg::dkt_out_t             res_o,
  input  logic                          res_taken_i,
  output dkt_pkg::dkt_ram_req_t         ram_req_o,
  input  logic [dkt_pkg::ARR_W-1:0]     ram_rd_data_i
);

  dkt_pkg::dkt_state_e state_q, state_d;

  logic [dkt_pkg::MODE_W-1:0] mode_q, mode_d;
  logic [dkt_pkg::PRIO_W-1:0] preq_q, preq_d;
  logic [dkt_pkg::PRIO_W-1:0] pnew_q, pnew_d;
  logic [dkt_pkg::ARR_W-1:0]  key_q, key_d;
  logic [dkt_pkg::ARR_W-1:0]  ntime_q, ntime_d;
  logic [dkt_pkg::SLOTS-1:0]  occ_q, occ_d;
  logic [dkt_pkg::CNT_W-1:0]  cnt_q, cnt_d;
  logic [dkt_pkg::IDX_W-1:0]  scan_q, scan_d;
  logic                       tag_vld_q, tag_vld_d;
  logic [dkt_pkg::IDX_W-1:0]  tag_q, tag_d;
  logic                       found_q, found_d;
  logic [dkt_pkg::IDX_W-1:0]  best_q, best_d;
  logic [dkt_pkg::ARR_W-1:0]  best_arr_q, best_arr_d;
  logic [dkt_pkg::STAT_W-1:0] rstat_q, rstat_d;
  logic [dkt_pkg::PRIO_W-1:0] rtp_q, rtp_d;
  logic [dkt_pkg::ARR_W-1:0]  rta_q, rta_d;

  logic                       eval_hit;
  logic                       scan_mode;
  logic                       pop_mode;
  logic [dkt_pkg::STAT_W-1:0] add_stat;
  logic [dkt_pkg::STAT_W-1:0] chg_stat;

  // slot scan compare on the entry whose data returns this cycle
  always_comb begin
    eval_hit = 1'b0;
    case (mode_q)
      dkt_pkg::MODE_POP_MAX, dkt_pkg::MODE_PEEK_MAX: begin
        eval_hit = occ_q[tag_q];
      end
      dkt_pkg::MODE_POP_EARLY, dkt_pkg::MODE_PEEK_EARLY: begin
        eval_hit = occ_q[tag_q] && (!found_q || (ram_rd_data_i < best_arr_q));
      end
      dkt_pkg::MODE_CHG_TIME: begin
        eval_hit = occ_q[tag_q] && !found_q && (ram_rd_data_i == key_q);
      end
      default: begin
        eval_hit = 1'b0;
      end
    endcase
  end

  assign scan_mode = (mode_q == dkt_pkg::MODE_POP_MAX) || (mode_q == dkt_pkg::MODE_POP_EARLY) ||
                     (mode_q == dkt_pkg::MODE_PEEK_MAX) ||
                     (mode_q == dkt_pkg::MODE_PEEK_EARLY) || (mode_q == dkt_pkg::MODE_CHG_TIME);
  assign pop_mode  = (mode_q == dkt_pkg::MODE_POP_MAX) || (mode_q == dkt_pkg::MODE_POP_EARLY);

  // checks of the direct operations
  always_comb begin
    if (cnt_q >= dkt_pkg::MAX_TASKS) begin
      add_stat = dkt_pkg::STAT_FULL;
    end else if (!dkt_pkg::prio_valid(preq_q)) begin
      add_stat = dkt_pkg::STAT_BADPRIO;
    end else if (occ_q[dkt_pkg::to_idx(preq_q)]) begin
      add_stat = dkt_pkg::STAT_INUSE;
    end else begin
      add_stat = dkt_pkg::STAT_OK;
    end
  end

  always_comb begin
    if (!dkt_pkg::prio_valid(preq_q) || !dkt_pkg::prio_valid(pnew_q)) begin
      chg_stat = dkt_pkg::STAT_BADPRIO;
    end else if (!occ_q[dkt_pkg::to_idx(preq_q)]) begin
      chg_stat = dkt_pkg::STAT_NOTFOUND;
    end else if ((pnew_q != preq_q) && occ_q[dkt_pkg::to_idx(pnew_q)]) begin
      chg_stat = dkt_pkg::STAT_INUSE;
    end else begin
      chg_stat = dkt_pkg::STAT_OK;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      dkt_pkg::S_IDLE: begin
        if (start_i) begin
          state_d = dkt_pkg::S_EXEC;
        end
      end
      dkt_pkg::S_EXEC: begin
        if (scan_mode) begin
          state_d = dkt_pkg::S_SCAN;
        end else if ((mode_q == dkt_pkg::MODE_CHG_PRIO) && (chg_stat == dkt_pkg::STAT_OK)) begin
          state_d = dkt_pkg::S_MOVE;
        end else begin
          state_d = dkt_pkg::S_RESP;
        end
      end
      dkt_pkg::S_MOVE: begin
        state_d = dkt_pkg::S_RESP;
      end
      dkt_pkg::S_SCAN: begin
        if (scan_q == dkt_pkg::LAST_IDX) begin
          state_d = dkt_pkg::S_WAIT;
        end
      end
      dkt_pkg::S_WAIT: begin
        state_d = dkt_pkg::S_FINISH;
      end
      dkt_pkg::S_FINISH: begin
        state_d = dkt_pkg::S_RESP;
      end
      dkt_pkg::S_RESP: begin
        if (res_taken_i) begin
          state_d = dkt_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = dkt_pkg::S_IDLE;
      end
    endcase
  end

  // datapath and ram requests
  always_comb begin
    mode_d     = mode_q;
    preq_d     = preq_q;
    pnew_d     = pnew_q;
    key_d      = key_q;
    ntime_d    = ntime_q;
    occ_d      = occ_q;
    cnt_d      = cnt_q;
    scan_d     = scan_q;
    tag_vld_d  = 1'b0;
    tag_d      = tag_q;
    found_d    = found_q;
    best_d     = best_q;
    best_arr_d = best_arr_q;
    rstat_d    = rstat_q;
    rtp_d      = rtp_q;
    rta_d      = rta_q;
    ram_req_o  = '0;

    if (tag_vld_q && eval_hit) begin
      found_d    = 1'b1;
      best_d     = tag_q;
      best_arr_d = ram_rd_data_i;
    end

    case (state_q)
      dkt_pkg::S_IDLE: begin
        if (start_i) begin
          mode_d  = req_i.mode;
          preq_d  = req_i.priority_req;
          pnew_d  = req_i.new_priority;
          key_d   = dkt_pkg::to_seconds(req_i.hours, req_i.minutes, req_i.seconds);
          ntime_d = dkt_pkg::to_seconds(req_i.new_hours, req_i.new_minutes,
                                        req_i.new_seconds);
        end
      end
      dkt_pkg::S_EXEC: begin
        found_d = 1'b0;
        scan_d  = dkt_pkg::FIRST_IDX;
        rtp_d   = '0;
        rta_d   = '0;
        rstat_d = dkt_pkg::STAT_OK;
        case (mode_q)
          dkt_pkg::MODE_ADD: begin
            rstat_d = add_stat;
            if (add_stat == dkt_pkg::STAT_OK) begin
              ram_req_o.wr_en   = 1'b1;
              ram_req_o.wr_addr = dkt_pkg::to_idx(preq_q);
              ram_req_o.wr_data = key_q;
              occ_d[dkt_pkg::to_idx(preq_q)] = 1'b1;
              cnt_d = cnt_q + 1'b1;
              rtp_d = preq_q;
              rta_d = key_q;
            end
          end
          dkt_pkg::MODE_CHG_PRIO: begin
            rstat_d           = chg_stat;
            ram_req_o.rd_addr = dkt_pkg::to_idx(preq_q);
          end
          dkt_pkg::MODE_POP_MAX, dkt_pkg::MODE_POP_EARLY, dkt_pkg::MODE_PEEK_MAX,
          dkt_pkg::MODE_PEEK_EARLY, dkt_pkg::MODE_CHG_TIME: begin
            rstat_d = dkt_pkg::STAT_OK;
          end
          default: begin
            rstat_d = dkt_pkg::STAT_NOTFOUND;
          end
        endcase
      end
      dkt_pkg::S_MOVE: begin
        // old entry data is on the read port now
        ram_req_o.wr_en   = 1'b1;
        ram_req_o.wr_addr = dkt_pkg::to_idx(pnew_q);
        ram_req_o.wr_data = ram_rd_data_i;
        occ_d[dkt_pkg::to_idx(preq_q)] = 1'b0;
        occ_d[dkt_pkg::to_idx(pnew_q)] = 1'b1;
        rtp_d = pnew_q;
        rta_d = ram_rd_data_i;
      end
      dkt_pkg::S_SCAN: begin
        ram_req_o.rd_addr = scan_q;
        tag_vld_d         = 1'b1;
        tag_d             = scan_q;
        scan_d            = scan_q + 1'b1;
      end
      dkt_pkg::S_FINISH: begin
        if (!found_q) begin
          rstat_d = (mode_q == dkt_pkg::MODE_CHG_TIME) ? dkt_pkg::STAT_NOTFOUND
                                                       : dkt_pkg::STAT_EMPTY;
        end else begin
          rtp_d = dkt_pkg::to_prio(best_q);
          rta_d = best_arr_q;
          if (pop_mode) begin
            occ_d[best_q] = 1'b0;
            if (cnt_q != '0) begin
              cnt_d = cnt_q - 1'b1;
            end
          end
          if (mode_q == dkt_pkg::MODE_CHG_TIME) begin
            ram_req_o.wr_en   = 1'b1;
            ram_req_o.wr_addr = best_q;
            ram_req_o.wr_data = ntime_q;
            rta_d             = ntime_q;
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= dkt_pkg::S_IDLE;
      occ_q     <= '0;
      cnt_q     <= '0;
      tag_vld_q <= 1'b0;
      found_q   <= 1'b0;
    end else begin
      state_q   <= state_d;
      occ_q     <= occ_d;
      cnt_q     <= cnt_d;
      tag_vld_q <= tag_vld_d;
      found_q   <= found_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mode_q     <= mode_d;
    preq_q     <= preq_d;
    pnew_q     <= pnew_d;
    key_q      <= key_d;
    ntime_q    <= ntime_d;
    scan_q     <= scan_d;
    tag_q      <= tag_d;
    best_q     <= best_d;
    best_arr_q <= best_arr_d;
    rstat_q    <= rstat_d;
    rtp_q      <= rtp_d;
    rta_q      <= rta_d;
  end

  assign busy_o      = (state_q != dkt_pkg::S_IDLE);
  assign res_valid_o = (state_q == dkt_pkg::S_RESP);

  always_comb begin
    res_o.status          = rstat_q;
    res_o.task_priority   = rtp_q;
    res_o.arrival_seconds = rta_q;
    res_o.task_count      = cnt_q;
  end

endmodule

// ----- sv/dual_key_task_table.sv -----
// ----------------------------------------------------------------------------
// dual_key_task_table: task table keyed by priority, searchable by arrival
// add, pop and peek by highest priority or earliest arrival, re-key by
// priority or by matching arrival time
// ----------------------------------------------------------------------------
//
//   channel   direction   handshake                 beat type
//   in        into block  in_valid_i / in_stall_o   dkt_pkg::dkt_in_t
//   out       from block  out_valid_o / out_stall_i dkt_pkg::dkt_out_t
//
// - one operation at a time; in_stall_o stays high from the accepted beat
//   until its result has moved into the output register
// - add, priority change and the unused code: EXEC, then MOVE for a valid
//   priority change, then RESP until the result is in the output register
// - pop, peek and time change: EXEC, then a slot scan through the single read
//   port of the arrival ram, one slot per cycle, then WAIT, FINISH and RESP
// - reset clears occupancy flags, task count and handshake state at once;
//   the arrival ram needs no clearing since only data of occupied slots is used
// - a stalled result waits in the output register while the next operation
//   is accepted and worked on
// ----------------------------------------------------------------------------
module dual_key_task_table (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  dkt_pkg::dkt_in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output dkt_pkg::dkt_out_t out_data_o
);

  logic                         seq_busy;
  logic                         seq_start;
  logic                         res_valid;
  logic                         res_take;
  dkt_pkg::dkt_out_t            res;
  dkt_pkg::dkt_ram_req_t        ram_req;
  logic [dkt_pkg::ARR_W-1:0]    ram_rd_data;

  logic                         out_valid_q, out_valid_d;
  dkt_pkg::dkt_out_t            out_q, out_d;

  // input side: a beat is taken whenever the sequencer is free
  assign in_stall_o = seq_busy;
  assign seq_start  = in_valid_i && !seq_busy;

  // result moves into the output register when it is empty or draining
  assign res_take = res_valid && (!out_valid_q || !out_stall_i);

  dkt_seq u_seq (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (seq_start),
    .req_i         (in_data_i),
    .busy_o        (seq_busy),
    .res_valid_o   (res_valid),
    .res_o         (res),
    .res_taken_i   (res_take),
    .ram_req_o     (ram_req),
    .ram_rd_data_i (ram_rd_data)
  );

  // arrival seconds per priority slot
  dkt_arrival_ram u_ram (
    .clk_i     (clk_i),
    .req_i     (ram_req),
    .rd_data_o (ram_rd_data)
  );

  // output register
  always_comb begin
    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (res_take) begin
      out_valid_d = 1'b1;
      out_d       = res;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ----- sv/dkt_checker.sv -----
// ----------------------------------------------------------------------------
// dkt_checker: port level checks of the task table
// result field consistency, busy after accept, held output beat
// ----------------------------------------------------------------------------
module dkt_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_stall_o,
  input logic              out_valid_o,
  input logic              out_stall_i,
  input dkt_pkg::dkt_out_t out_data_o
);

  // held output beat keeps its payload
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("output beat changed while stalled");

  // one operation at a time: busy right after an accepted beat
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input taken while an operation is in flight");

  // failed operations report no task
  a_fail_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.status != dkt_pkg::STAT_OK) |->
      (out_data_o.task_priority == '0) && (out_data_o.arrival_seconds == '0))
    else $error("failed operation reports a task");

  // successful operations report a real task and time
  a_ok_task: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.status == dkt_pkg::STAT_OK)
      |-> (out_data_o.task_priority != '0) &&
          (out_data_o.arrival_seconds <= dkt_pkg::DAY_LAST))
    else $error("successful operation with bad task fields");

  // count never exceeds table capacity
  a_count_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.task_count <= dkt_pkg::MAX_TASKS)
    else $error("task count above capacity");

endmodule

bind dual_key_task_table dkt_checker u_dkt_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);
